FILE: hw/rtl/ptlp_pkg.sv
`default_nettype none

package ptlp_pkg;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int DIST_W    = 34;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths.
  localparam int DIFF_W = COORD_W + 1;        // query minus base
  localparam int PD_W   = COORD_W + DIFF_W;   // one term of the dot product
  localparam int DOT_W  = PD_W + 2;           // sum of three terms
  localparam int NORM_W = 2 * COORD_W;        // squared length of the direction
  localparam int LO_W   = 34;                 // low slice of dot for the split multiply
  localparam int HI_W   = DOT_W - LO_W;       // signed high slice of dot
  localparam int PL_W   = COORD_W + LO_W + 1;
  localparam int PH_W   = COORD_W + HI_W;
  localparam int NUM_W  = PH_W + LO_W;        // direction times dot
  localparam int MAG_W  = NUM_W - 1;          // magnitude of that product
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;

  // Divider and square root sizes.
  localparam int DIV_STEPS  = 34;
  localparam int QUOT_W     = DIV_STEPS + 1;
  localparam int SQRT_STEPS = DIST_W;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int SQRT_LAT   = SQRT_STEPS + 2;

  // Stage count from an accepted beat to its result register.
  localparam int TOTAL_LAT = 6 + DIV_LAT + 4 + SQRT_LAT + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z = 3'd5;

  localparam logic [COORD_W-1:0] DIR_X_RESET = 32'h0001_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_z;
    logic        [DIST_W-1:0]  distance;
    logic                      degenerate;
  } result_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [NORM_W-1:0] den;
    logic              neg;
  } div_in_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              big;
    logic              neg;
  } div_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptlp_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, rounded half away
// from zero on the magnitude. Quotients of 2^34 and more only raise big.
module ptlp_div (
  input  wire                  clk_i,
  input  wire ptlp_pkg::div_in_t div_i,
  output ptlp_pkg::div_out_t   div_o
);

  localparam int MagW   = ptlp_pkg::MAG_W;
  localparam int NormW  = ptlp_pkg::NORM_W;
  localparam int Steps  = ptlp_pkg::DIV_STEPS;
  localparam int QuotW  = ptlp_pkg::QUOT_W;

  logic [MagW-1:0]  rem_q  [0:Steps];
  logic [NormW-1:0] den_q  [0:Steps];
  logic [Steps-1:0] quot_q [0:Steps];
  logic             neg_q  [0:Steps];
  logic             big_q  [0:Steps];

  ptlp_pkg::div_out_t out_q;
  logic               rnd_up;

  // Entry stage: flag quotients that cannot fit in the step count.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= div_i.mag;
    den_q[0]  <= div_i.den;
    quot_q[0] <= '0;
    neg_q[0]  <= div_i.neg;
    big_q[0]  <= div_i.mag >= ({{(MagW-NormW){1'b0}}, div_i.den} << Steps);
  end

  // One compare and subtract per stage, most significant quotient bit first.
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Sh = Steps - 1 - k;
    logic [MagW-1:0] trial;
    logic            fit;

    assign trial = {{(MagW-NormW){1'b0}}, den_q[k]} << Sh;
    assign fit   = rem_q[k] >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= fit ? (rem_q[k] - trial) : rem_q[k];
      quot_q[k+1] <= quot_q[k] | ({{(Steps-1){1'b0}}, fit} << Sh);
      den_q[k+1]  <= den_q[k];
      neg_q[k+1]  <= neg_q[k];
      big_q[k+1]  <= big_q[k];
    end
  end

  // Round up when the remainder is at least half the divisor.
  assign rnd_up = {rem_q[Steps][NormW-1:0], 1'b0} >= {1'b0, den_q[Steps]};

  always_ff @(posedge clk_i) begin
    out_q.quot <= {1'b0, quot_q[Steps]} + QuotW'(rnd_up);
    out_q.big  <= big_q[Steps];
    out_q.neg  <= neg_q[Steps];
  end

  assign div_o = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ptlp_sqrt.sv
`default_nettype none

// Pipelined integer square root, one root bit per stage, rounded to nearest
// with ties up and saturated to the distance range.
module ptlp_sqrt (
  input  wire                              clk_i,
  input  wire [ptlp_pkg::SUM_W-1:0]        sum_i,
  output logic [ptlp_pkg::DIST_W-1:0]      root_o
);

  localparam int SumW  = ptlp_pkg::SUM_W;
  localparam int RootW = ptlp_pkg::DIST_W;
  localparam int Steps = ptlp_pkg::SQRT_STEPS;
  localparam int WideW = SumW + 1;

  logic [SumW-1:0]  rem_q  [0:Steps];
  logic [RootW-1:0] root_q [0:Steps];
  logic [RootW-1:0] out_q;
  logic [RootW:0]   root_inc;
  logic             rnd_up;

  // Entry stage.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= sum_i;
    root_q[0] <= '0;
  end

  // Try the next root bit: the square grows by 2*r*2^i + 2^(2i).
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;
    logic [WideW-1:0] delta;
    logic             fit;

    assign delta = ({{(WideW-RootW){1'b0}}, root_q[k]} << (Bit + 1))
                 + ({{(WideW-1){1'b0}}, 1'b1} << (2 * Bit));
    assign fit   = {1'b0, rem_q[k]} >= delta;

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= fit ? (rem_q[k] - delta[SumW-1:0]) : rem_q[k];
      root_q[k+1] <= root_q[k] | ({{(RootW-1){1'b0}}, fit} << Bit);
    end
  end

  // The remainder is s - r*r; round up when it exceeds r.
  assign rnd_up   = rem_q[Steps] > {{(SumW-RootW){1'b0}}, root_q[Steps]};
  assign root_inc = {1'b0, root_q[Steps]} + {{RootW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i) begin
    if (!rnd_up) begin
      out_q <= root_q[Steps];
    end else if (root_inc[RootW]) begin
      out_q <= '1;
    end else begin
      out_q <= root_inc[RootW-1:0];
    end
  end

  assign root_o = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/point_to_line_projection.sv
// Channel   Ports                                     Direction  Notes
// query     start_i, busy_o, query_i                  in         beat when start_i && !busy_o
// result    done_o, result_o                          out        one-cycle strobe, no back-pressure
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i          in         write per cycle, unknown index ignored
//
// A new query beat is taken every cycle; busy_o stays low.
// Each result passes through six arithmetic stages, a
// 36-stage divider (one quotient bit per stage), four stages of saturation
// and squaring, a 36-stage square root and the result register.
// Reset clears the valid line and loads the direction (1.0, 0, 0) and base 0.
// The receiver cannot stall, so the pipeline advances on every clock.

`default_nettype none

module point_to_line_projection (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  output logic                                  busy_o,
  input  wire ptlp_pkg::query_t                 query_i,
  output logic                                  done_o,
  output ptlp_pkg::result_t                     result_o,
  input  wire                                   cfg_we_i,
  input  wire [ptlp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire [ptlp_pkg::COORD_W-1:0]           cfg_wdata_i
);

  localparam int CoordW = ptlp_pkg::COORD_W;
  localparam int DiffW  = ptlp_pkg::DIFF_W;
  localparam int PdW    = ptlp_pkg::PD_W;
  localparam int DotW   = ptlp_pkg::DOT_W;
  localparam int NormW  = ptlp_pkg::NORM_W;
  localparam int LoW    = ptlp_pkg::LO_W;
  localparam int PlW    = ptlp_pkg::PL_W;
  localparam int PhW    = ptlp_pkg::PH_W;
  localparam int NumW   = ptlp_pkg::NUM_W;
  localparam int MagW   = ptlp_pkg::MAG_W;
  localparam int SqW    = ptlp_pkg::SQ_W;
  localparam int SumW   = ptlp_pkg::SUM_W;
  localparam int DistW  = ptlp_pkg::DIST_W;
  localparam int Lat    = ptlp_pkg::TOTAL_LAT;
  localparam int DivOut = 5 + ptlp_pkg::DIV_LAT;   // stage slot of the divider output
  localparam int PSlot  = DivOut + 1;               // slot of the saturated projection
  localparam int PW     = CoordW + 5;               // base plus offset

  localparam logic signed [PW-1:0] MaxP = PW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic signed [PW-1:0] MinP = -MaxP - PW'(1);

  // Configuration registers.
  logic signed [CoordW-1:0] dir_q  [3];
  logic signed [CoordW-1:0] base_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0]  <= ptlp_pkg::DIR_X_RESET;
      dir_q[1]  <= '0;
      dir_q[2]  <= '0;
      base_q[0] <= '0;
      base_q[1] <= '0;
      base_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptlp_pkg::CFG_DIR_X:  dir_q[0]  <= cfg_wdata_i;
        ptlp_pkg::CFG_DIR_Y:  dir_q[1]  <= cfg_wdata_i;
        ptlp_pkg::CFG_DIR_Z:  dir_q[2]  <= cfg_wdata_i;
        ptlp_pkg::CFG_BASE_X: base_q[0] <= cfg_wdata_i;
        ptlp_pkg::CFG_BASE_Y: base_q[1] <= cfg_wdata_i;
        ptlp_pkg::CFG_BASE_Z: base_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline takes a beat every cycle.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic signed [CoordW-1:0] qin [3];
  assign qin[0] = query_i.query_x;
  assign qin[1] = query_i.query_y;
  assign qin[2] = query_i.query_z;

  // Valid and degenerate flags travel alongside the data.
  logic [Lat-1:0] vld_q;
  logic [Lat-1:3] deg_q;

  logic [NormW-1:0] norm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= {deg_q[Lat-2:3], norm3_q == '0};
  end

  // Query coordinates wait in a delay line until the distance stage.
  logic [2:0][CoordW-1:0] qline_q [0:PSlot];

  always_ff @(posedge clk_i) begin
    qline_q[0] <= {qin[2], qin[1], qin[0]};
    for (int n = 1; n <= PSlot; n++) begin
      qline_q[n] <= qline_q[n-1];
    end
  end

  // Stage 1: query minus base.
  logic signed [DiffW-1:0] diff1_q [3];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      diff1_q[c] <= DiffW'(qin[c]) - DiffW'(base_q[c]);
    end
  end

  // Stage 2: products for the dot product and the squared length.
  logic signed [PdW-1:0]   pd2_q [3];
  logic signed [NormW-1:0] nn2_q [3];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      pd2_q[c] <= dir_q[c] * diff1_q[c];
      nn2_q[c] <= dir_q[c] * dir_q[c];
    end
  end

  // Stage 3: the two sums.
  logic signed [DotW-1:0] dot3_q;
  always_ff @(posedge clk_i) begin
    dot3_q  <= DotW'(pd2_q[0]) + DotW'(pd2_q[1]) + DotW'(pd2_q[2]);
    norm3_q <= $unsigned(nn2_q[0]) + $unsigned(nn2_q[1]) + $unsigned(nn2_q[2]);
  end

  // Stage 4: direction times dot, as two partial products.
  logic signed [PlW-1:0] pl4_q [3];
  logic signed [PhW-1:0] ph4_q [3];
  logic [NormW-1:0]      norm4_q;
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      pl4_q[c] <= dir_q[c] * $signed({1'b0, dot3_q[LoW-1:0]});
      ph4_q[c] <= dir_q[c] * $signed(dot3_q[DotW-1:LoW]);
    end
    norm4_q <= norm3_q;
  end

  // Stage 5: combine the partial products.
  logic signed [NumW-1:0] num5_q [3];
  logic [NormW-1:0]       norm5_q;
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      num5_q[c] <= (NumW'(ph4_q[c]) <<< LoW) + NumW'(pl4_q[c]);
    end
    norm5_q <= norm4_q;
  end

  // Stage 6: sign and magnitude for the divider.
  ptlp_pkg::div_in_t div6_q [3];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      div6_q[c].neg <= num5_q[c][NumW-1];
      div6_q[c].mag <= num5_q[c][NumW-1] ? MagW'(-num5_q[c]) : MagW'(num5_q[c]);
      div6_q[c].den <= norm5_q;
    end
  end

  // One divider per coordinate.
  ptlp_pkg::div_out_t divo [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    ptlp_div u_div (
      .clk_i (clk_i),
      .div_i (div6_q[c]),
      .div_o (divo[c])
    );
  end

  // Projection: base plus signed offset, saturated; the base when degenerate.
  logic [2:0][CoordW-1:0] pline_q [PSlot:Lat-1];
  logic [2:0][CoordW-1:0] p_d;
  logic signed [PW-1:0]   off  [3];
  logic signed [PW-1:0]   psum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      off[c]  = divo[c].neg ? -PW'({1'b0, divo[c].quot}) : PW'({1'b0, divo[c].quot});
      psum[c] = PW'(base_q[c]) + off[c];
      if (deg_q[DivOut]) begin
        p_d[c] = base_q[c];
      end else if (divo[c].big) begin
        p_d[c] = divo[c].neg ? MinP[CoordW-1:0] : MaxP[CoordW-1:0];
      end else if (psum[c] > MaxP) begin
        p_d[c] = MaxP[CoordW-1:0];
      end else if (psum[c] < MinP) begin
        p_d[c] = MinP[CoordW-1:0];
      end else begin
        p_d[c] = psum[c][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pline_q[PSlot] <= p_d;
    for (int n = PSlot + 1; n < Lat; n++) begin
      pline_q[n] <= pline_q[n-1];
    end
  end

  // Distance: difference, squares, sum.
  logic signed [DiffW-1:0] df_q [3];
  logic signed [SqW-1:0]   sq_q [3];
  logic [SumW-1:0]         sum_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      df_q[c] <= DiffW'($signed(qline_q[PSlot][c])) - DiffW'($signed(pline_q[PSlot][c]));
      sq_q[c] <= df_q[c] * df_q[c];
    end
    sum_q <= SumW'($unsigned(sq_q[0])) + SumW'($unsigned(sq_q[1]))
           + SumW'($unsigned(sq_q[2]));
  end

  logic [DistW-1:0] root;
  ptlp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .sum_i  (sum_q),
    .root_o (root)
  );

  // Result register.
  logic [DistW-1:0] dist_q;
  always_ff @(posedge clk_i) begin
    dist_q <= root;
  end

  assign done_o              = vld_q[Lat-1];
  assign result_o.proj_x     = pline_q[Lat-1][0];
  assign result_o.proj_y     = pline_q[Lat-1][1];
  assign result_o.proj_z     = pline_q[Lat-1][2];
  assign result_o.distance   = dist_q;
  assign result_o.degenerate = deg_q[Lat-1];

  // Every result traces back to a beat taken a fixed latency earlier.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Lat))
    else $error("result without a matching query beat");

  // A zero direction seen in the sum stage reaches the output flagged.
  a_degen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && norm3_q == '0) |-> ##(Lat-3) (done_o && result_o.degenerate))
    else $error("degenerate flag lost in the pipeline");

endmodule

`default_nettype wire
